### src/box_blur_3x3_edge_clipped_defines.svh
`ifndef BOX_BLUR_3X3_EDGE_CLIPPED_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_CLIPPED_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BB3_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BB3_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/bb3_pkg.sv
`timescale 1ns / 1ps
package bb3_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam int CFG_DATA_W = 11;
   localparam int SUM_W      = 12;  // 9 * 255
   localparam int NUM_W      = 13;  // 2 * sum + n
   localparam int RECIP_W    = 20;
   localparam int RECIP_SH   = 20;
   localparam int PROD_W     = NUM_W + RECIP_W;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       frame_done;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SUM,
      ST_MUL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;   // take the beat, read both line stores
      logic step;   // shift window, write line stores, advance input position
      logic sum;    // clipped sums and divisor
      logic mul;    // reciprocal multiply
      logic emit;   // load the output register
   } cmd_type;

   typedef struct packed {
      logic ignore;     // flush beat with no pixel of this frame taken yet
      logic emit_flag;  // current item produces a result
      logic out_free;   // output register can take a result
   } status_type;

   // ceil(2^20 / (2*n)) for every divisor the clipped window can produce
   function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
      logic [RECIP_W-1:0] m;
      begin
         case (n)
            4'd1:    m = 20'd524288;
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131072;
            4'd6:    m = 20'd87382;
            4'd9:    m = 20'd58255;
            default: m = '0;
         endcase
         return m;
      end
   endfunction

endpackage

### src/bb3_ctrl.sv
`timescale 1ns / 1ps
module bb3_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  bb3_pkg::status_type status,
   output bb3_pkg::cmd_type    cmd
);
   import bb3_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !status.ignore) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = status.emit_flag ? ST_SUM : ST_IDLE;
         end
         ST_SUM:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid && !status.ignore;
         end
         ST_FETCH: cmd.step = 1'b1;
         ST_SUM:   cmd.sum  = 1'b1;
         ST_MUL:   cmd.mul  = 1'b1;
         ST_EMIT:  cmd.emit = status.out_free;
         default:  cmd = '0;
      endcase
   end

endmodule

### src/bb3_datapath.sv
`timescale 1ns / 1ps
module bb3_datapath #(
   parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bb3_pkg::req_payload_type req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output bb3_pkg::rsp_payload_type rsp_payload,
   input  logic                    cfg_we,
   input  logic                    cfg_idx,
   input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data,
   output logic [31:0]             cfg_rdata,
   input  bb3_pkg::cmd_type         cmd,
   output bb3_pkg::status_type      status
);
   import bb3_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int IRW = $clog2(MAX_HEIGHT + 2);
   localparam int RST_W = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
   localparam int RST_H = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

   logic [WW-1:0]  width_ff;
   logic [HW-1:0]  height_ff;
   logic [CW-1:0]  in_col_ff, in_col_in;
   logic [IRW-1:0] in_row_ff, in_row_in;
   logic [CW-1:0]  out_col_ff, out_col_in;
   logic [HW-1:0]  out_row_ff, out_row_in;

   logic [23:0] up_mem  [MAX_WIDTH];
   logic [23:0] mid_mem [MAX_WIDTH];
   logic [23:0] up_rd_ff, mid_rd_ff, px_ff;
   logic [23:0] win_ff [3][3];    // [column][row], rows upper/middle/newest

   logic [NUM_W-1:0]   x_ff [3];
   logic [RECIP_W-1:0] m_ff;
   logic [PROD_W-1:0]  prod_ff [3];
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_payload_ff;

   // configuration write value, clamped to 1..MAX
   logic [13:0] cfg_ext;
   logic [WW-1:0] width_cl;
   logic [HW-1:0] height_cl;

   always_comb begin
      cfg_ext = 14'(cfg_data);
      if (cfg_ext == 14'd0) begin
         width_cl  = WW'(1);
         height_cl = HW'(1);
      end else begin
         width_cl  = (cfg_ext > 14'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(cfg_ext);
         height_cl = (cfg_ext > 14'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_ext);
      end
   end

   always_comb begin
      case (cfg_idx)
         CSR_FRAME_WIDTH:  cfg_rdata = 32'(width_ff);
         CSR_FRAME_HEIGHT: cfg_rdata = 32'(height_ff);
         default:          cfg_rdata = '0;
      endcase
   end

   // position bookkeeping
   logic [WW-1:0] in_col_p1, out_col_p1;
   logic [HW-1:0] out_row_p1;
   logic top, bottom, left, right, done;

   always_comb begin
      in_col_p1  = WW'(in_col_ff) + WW'(1);
      out_col_p1 = WW'(out_col_ff) + WW'(1);
      out_row_p1 = out_row_ff + HW'(1);
      top    = out_row_ff != '0;
      bottom = out_row_p1 < height_ff;
      left   = out_col_ff != '0;
      right  = out_col_p1 < width_ff;
      done   = !bottom && !right;

      status.ignore    = req_payload.func && (in_row_ff == '0) && (in_col_ff == '0);
      status.emit_flag = (in_row_ff >= IRW'(2)) || ((in_row_ff == IRW'(1)) && (in_col_ff != '0));
      status.out_free  = !rsp_valid_ff || !rsp_stall;

      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (cmd.step) begin
         if (in_col_p1 >= width_ff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + IRW'(1);
         end else begin
            in_col_in = in_col_p1[CW-1:0];
         end
      end

      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (cmd.emit) begin
         if (done) begin
            out_col_in = '0;
            out_row_in = '0;
            in_col_in  = '0;
            in_row_in  = '0;
         end else if (!right) begin
            out_col_in = '0;
            out_row_in = out_row_p1;
         end else begin
            out_col_in = out_col_p1[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WW'(RST_W);
         height_ff  <= HW'(RST_H);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (cfg_we) begin
         if (cfg_idx == CSR_FRAME_WIDTH) width_ff <= width_cl;
         else                            height_ff <= height_cl;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // line stores: read on the accept edge, written back in the next cycle
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         up_rd_ff  <= up_mem[in_col_ff];
         mid_rd_ff <= mid_mem[in_col_ff];
      end
      if (cmd.step) begin
         up_mem[in_col_ff]  <= mid_rd_ff;
         mid_mem[in_col_ff] <= px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         // flush beats and pixels past the last line count as zero
         if (req_payload.func || (in_row_ff >= IRW'(height_ff))) px_ff <= '0;
         else px_ff <= {req_payload.red_in, req_payload.green_in, req_payload.blue_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) win_ff[c][r] <= '0;
         end
      end else if (cmd.step) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2][0] <= up_rd_ff;
         win_ff[2][1] <= mid_rd_ff;
         win_ff[2][2] <= px_ff;
      end
   end

   // clipped sums
   logic [SUM_W-1:0] sum [3];
   logic [1:0] rows, cols;
   logic [3:0] n;
   logic use_c [3];
   logic use_r [3];

   always_comb begin
      use_c[0] = left;  use_c[1] = 1'b1; use_c[2] = right;
      use_r[0] = top;   use_r[1] = 1'b1; use_r[2] = bottom;
      rows = 2'd1 + 2'(top) + 2'(bottom);
      cols = 2'd1 + 2'(left) + 2'(right);
      n    = 4'(rows) * 4'(cols);
      for (int ch = 0; ch < 3; ch++) sum[ch] = '0;
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            if (use_c[c] && use_r[r]) begin
               for (int ch = 0; ch < 3; ch++)
                  sum[ch] = sum[ch] + SUM_W'(win_ff[c][r][8*(2-ch) +: 8]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         for (int ch = 0; ch < 3; ch++) x_ff[ch] <= {sum[ch], 1'b0} + NUM_W'(n);
         m_ff <= recip(n);
      end
      if (cmd.mul) begin
         for (int ch = 0; ch < 3; ch++) prod_ff[ch] <= PROD_W'(x_ff[ch]) * PROD_W'(m_ff);
      end
      if (cmd.emit) begin
         rsp_payload_ff.red_out    <= prod_ff[0][RECIP_SH +: 8];
         rsp_payload_ff.green_out  <= prod_ff[1][RECIP_SH +: 8];
         rsp_payload_ff.blue_out   <= prod_ff[2][RECIP_SH +: 8];
         rsp_payload_ff.frame_done <= done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### src/box_blur_3x3_edge_clipped.sv
`timescale 1ns / 1ps
// 3x3 box blur over an RGB frame streamed in raster order, one pixel per beat.
// Each result is the rounded-half-up mean per channel of the neighborhood
// clipped at the frame edges; result (r,c) leaves on the beat that brings
// raster position (r+1)*W+c+1, so after the last pixel send W+1 flush beats
// (func=1) to drain the frame; frame_done marks its final result. A beat that
// yields a result goes through accept with line store read, window shift with
// store write, clipped sum, reciprocal multiply and output load; a beat with no
// result ends after the shift, and a flush before any pixel of a frame is taken
// and dropped in idle. The pace is set by the single-port line store access and
// the sum/multiply stages of the shared datapath. The output register lets
// the next beat be accepted while a result waits. Registers: frame_width at
// 0x0, frame_height at 0x4, 11 bits, clamped to 1..MAX; any write restarts
// the frame. Line stores need no clearing after reset.
module box_blur_3x3_edge_clipped #(
   parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  bb3_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output bb3_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [2:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);
   import bb3_pkg::*;

`include "box_blur_3x3_edge_clipped_defines.svh"

   cmd_type    cmd;
   status_type status;
   logic       cfg_we;

   // zero-wait register port; word select on the address bit above the byte offset
   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   bb3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bb3_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cfg_we      (cfg_we),
      .cfg_idx     (csr_paddr[2]),
      .cfg_data    (csr_pwdata[CFG_DATA_W-1:0]),
      .cfg_rdata   (csr_prdata),
      .cmd         (cmd),
      .status      (status)
   );

   // a taken beat that is not dropped holds the input side off next cycle
   `BB3_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall && !status.ignore, req_stall, "input not held off while an item is in work")
   // never overwrite a result that is still waiting
   `BB3_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.emit, !rsp_valid || !rsp_stall, "result loaded over a waiting one")
   // a loaded result shows up on the port
   `BB3_ASSERT_NEXT(a_emit_shows, clock, reset, cmd.emit, rsp_valid, "loaded result not presented")

endmodule
